// File: rtl/iflpm_pkg.sv
// ============================================================================
// iflpm_pkg
// Shared types and constants for the IPv4 longest-prefix-match unit.
// ============================================================================
package iflpm_pkg;

    localparam int DEF_ROUTE_ENTRIES = 64;

    localparam logic [2:0] ST_LOCAL   = 3'd0;
    localparam logic [2:0] ST_FORWARD = 3'd1;
    localparam logic [2:0] ST_TTL     = 3'd2;
    localparam logic [2:0] ST_NOROUTE = 3'd3;
    localparam logic [2:0] ST_ADDED   = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_HEADER = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input transaction accepted
        logic scan_start; // clear best-match tracking, index 0
        logic scan_step;  // evaluate read entry, advance index
        logic out_load;   // capture result into output register
        logic out_take;   // result transaction completed
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic add_op;     // accepted item is a route add
        logic last;       // accepted header word is last
        logic need_scan;  // decision needs a table scan
        logic scan_done;  // last entry evaluated
    } t_sts;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] m;
        m = '0;
        if (len >= 6'd32) m = '1;
        else if (len != 6'd0) m = ~(32'hFFFF_FFFF >> len);
        return m;
    endfunction

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// File: rtl/ipv4_forward_lpm_unit.sv
// ============================================================================
// ipv4_forward_lpm_unit
// IPv4 forwarding decision with longest-prefix-match route table.
// ============================================================================
// Takes route-add transactions and 16-bit header word transactions. A header
// word is accepted and then absorbed. On the last word, local delivery, TTL
// discard and no route for an empty table are decided in the absorb cycle;
// otherwise the route table memory is scanned one entry per cycle (accept,
// absorb, scan of route_count entries, finish). The result is held in an
// output register and no new transaction is taken until it has been taken
// downstream, so result stalls hold off the next transaction.
module ipv4_forward_lpm_unit
    import iflpm_pkg::*;
#(
    parameter int ROUTE_ENTRIES = DEF_ROUTE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [15:0] i_header_word,
    input  logic        i_last,
    input  logic [31:0] i_route_prefix,
    input  logic [5:0]  i_route_length,
    input  logic [31:0] i_route_next_hop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_next_hop,
    output logic [7:0]  o_new_ttl,
    output logic [15:0] o_new_checksum
);

    logic [31:0] r_local_address;
    t_cmd cmd;
    t_sts sts;

    // local address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_local_address <= '0;
        else if (i_cfg_we) r_local_address <= i_cfg_wdata;
    end

    iflpm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .o_ready_int(o_ready), .i_out_ready(i_ready), .o_out_valid(o_valid),
        .i_sts(sts), .o_cmd(cmd)
    );

    iflpm_dp #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_local_address(r_local_address),
        .i_opcode(i_opcode), .i_header_word(i_header_word), .i_last(i_last),
        .i_route_prefix(i_route_prefix), .i_route_length(i_route_length),
        .i_route_next_hop(i_route_next_hop), .i_cmd(cmd), .o_sts(sts),
        .o_status(o_status), .o_next_hop(o_next_hop), .o_new_ttl(o_new_ttl),
        .o_new_checksum(o_new_checksum)
    );

endmodule

// File: rtl/iflpm_ctrl.sv
// ============================================================================
// iflpm_ctrl
// Sequencer: accept, route-table scan, result hand-off.
// ============================================================================
module iflpm_ctrl
    import iflpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready_int,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    // out register frees up in the same cycle it is taken
    logic out_free;
    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid;
        o_cmd = '0;
        o_ready_int = 1'b0;
        if (r_ovalid && i_out_ready) begin
            o_cmd.out_take = 1'b1;
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                // no new transaction while a result still waits
                o_ready_int = !r_ovalid;
                if (i_valid && !r_ovalid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.add_op && !i_sts.last) begin
                    n_state = S_IDLE;
                end else if (!i_sts.add_op && i_sts.need_scan) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

// File: rtl/iflpm_dp.sv
// ============================================================================
// iflpm_dp
// Header gathering, route table memory, match scan and output register.
// ============================================================================
module iflpm_dp
    import iflpm_pkg::*;
#(
    parameter int ROUTE_ENTRIES = DEF_ROUTE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_local_address,
    input  logic        i_opcode,
    input  logic [15:0] i_header_word,
    input  logic        i_last,
    input  logic [31:0] i_route_prefix,
    input  logic [5:0]  i_route_length,
    input  logic [31:0] i_route_next_hop,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [2:0]  o_status,
    output logic [31:0] o_next_hop,
    output logic [7:0]  o_new_ttl,
    output logic [15:0] o_new_checksum
);

    localparam int AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CW = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(ROUTE_ENTRIES);

    // route table memory: prefix, length, hop
    logic [69:0] mem [ROUTE_ENTRIES];
    logic [69:0] r_rd;

    logic [CW-1:0] r_count;
    logic [4:0]    r_pos;
    logic [15:0]   r_sum;
    logic [7:0]    r_ttl;
    logic [31:0]   r_dst;

    // latched item
    logic        r_op, r_last;
    logic [31:0] r_pfx, r_hop_in;
    logic [5:0]  r_len;

    // snapshot for the decision
    logic [15:0] r_dsum;
    logic [7:0]  r_dttl;
    logic [31:0] r_ddst;

    logic [CW-1:0] r_idx;
    logic          r_found;
    logic [5:0]    r_blen;
    logic [31:0]   r_bhop;

    logic [5:0]  len_sat;
    logic [15:0] w_in, sum_nx;
    logic [15:0] r_w;
    logic        full;
    logic        r_vld_rd;

    assign len_sat = (r_len > 6'd32) ? 6'd32 : r_len;
    assign full    = (r_count >= CNT_MAX);
    assign w_in    = (r_pos == 5'd4) ? (r_w - 16'h0100) : r_w;
    assign sum_nx  = (r_pos == 5'd5) ? r_sum : ones_add(r_sum, w_in);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= i_opcode;
            r_last <= i_last;
            r_w <= i_header_word;
            r_pfx <= i_route_prefix;
            r_len <= i_route_length;
            r_hop_in <= i_route_next_hop;
        end
    end

    // header accumulation and table write happen in the decide cycle
    logic decide;
    logic r_dec;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dec <= 1'b0;
        else r_dec <= i_cmd.accept;
    end
    assign decide = r_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos <= '0;
            r_sum <= '0;
            r_ttl <= '0;
            r_dst <= '0;
        end else if (decide) begin
            if (r_op == OP_ADD) begin
                if (!full) r_count <= r_count + 1'b1;
            end else if (r_last) begin
                r_pos <= '0;
                r_sum <= '0;
                r_ttl <= '0;
                r_dst <= '0;
            end else begin
                r_sum <= sum_nx;
                if (r_pos == 5'd4) r_ttl <= r_w[15:8];
                if (r_pos == 5'd8) r_dst[31:16] <= r_w;
                if (r_pos == 5'd9) r_dst[15:0] <= r_w;
                if (r_pos != 5'd31) r_pos <= r_pos + 1'b1;
            end
        end
    end

    // final-word view of the gathered fields
    logic [7:0]  f_ttl;
    logic [31:0] f_dst;
    always_comb begin
        f_ttl = (r_pos == 5'd4) ? r_w[15:8] : r_ttl;
        f_dst = r_dst;
        if (r_pos == 5'd8) f_dst[31:16] = r_w;
        if (r_pos == 5'd9) f_dst[15:0] = r_w;
    end

    always_ff @(posedge i_clk) begin
        if (decide) begin
            r_dsum <= sum_nx;
            r_dttl <= f_ttl;
            r_ddst <= f_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (decide && r_op == OP_ADD && !full)
            mem[r_count[AW-1:0]] <= {r_pfx & prefix_mask(len_sat), len_sat, r_hop_in};
    end

    // scan: address r_idx (0 at scan start) read, evaluated next cycle
    logic [CW-1:0] rd_idx;
    assign rd_idx = i_cmd.scan_start ? '0 : r_idx;
    always_ff @(posedge i_clk) begin
        r_rd <= mem[rd_idx[AW-1:0]];
    end

    logic [31:0] e_pfx, e_hop;
    logic [5:0]  e_len;
    logic        hit;
    assign e_pfx = r_rd[69:38];
    assign e_len = r_rd[37:32];
    assign e_hop = r_rd[31:0];
    assign hit = r_vld_rd && ((r_ddst & prefix_mask(e_len)) == e_pfx)
                 && (!r_found || e_len > r_blen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_found <= 1'b0;
            r_vld_rd <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_idx <= CW'(1);
            r_found <= 1'b0;
            r_vld_rd <= 1'b1;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            r_vld_rd <= (r_idx < r_count);
            if (hit) r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && hit) begin
            r_blen <= e_len;
            r_bhop <= e_hop;
        end
    end

    // entry r_idx-1 is in r_rd; last one is count-1
    assign o_sts.add_op    = (r_op == OP_ADD);
    assign o_sts.last      = r_last;
    assign o_sts.need_scan = (f_dst != i_local_address) && (f_ttl != 8'd0)
                             && (r_count != '0);
    assign o_sts.scan_done = (r_idx >= r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_next_hop <= '0;
            o_new_checksum <= '0;
            o_new_ttl <= '0;
            if (r_op == OP_ADD) begin
                o_status <= full ? ST_FULL : ST_ADDED;
            end else if (decide) begin
                o_new_ttl <= f_ttl;
                if (f_dst == i_local_address) o_status <= ST_LOCAL;
                else if (f_ttl == 8'd0) o_status <= ST_TTL;
                else o_status <= ST_NOROUTE;
            end else begin
                o_new_ttl <= r_dttl;
                if (r_found) begin
                    o_status <= ST_FORWARD;
                    o_next_hop <= r_bhop;
                    o_new_ttl <= r_dttl - 8'd1;
                    o_new_checksum <= ~r_dsum;
                end else begin
                    o_status <= ST_NOROUTE;
                end
            end
        end
    end

endmodule
